FILE: rtl/icmp_erc_pkg.sv
// Shared types, constants and checksum arithmetic for the ICMP echo reply classifier.
`timescale 1ns / 1ps

package icmp_erc_pkg;

  localparam logic [3:0]  IHL_MASK          = 4'hF;
  localparam logic [15:0] SUM_GOOD          = 16'hFFFF;
  localparam logic [7:0]  ECHO_REQUEST_TYPE = 8'd8;
  localparam logic [6:0]  POS_MAX           = 7'd127;
  localparam logic [6:0]  ID_HIGH_OFFSET    = 7'd4;
  localparam logic [6:0]  ID_LOW_OFFSET     = 7'd5;

  typedef enum logic [1:0] {
    VERDICT_FOR_US       = 2'd0,
    VERDICT_OWN_REQUEST  = 2'd1,
    VERDICT_ANOMALY      = 2'd2,
    VERDICT_BAD_CHECKSUM = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  icmp_type;
    logic [15:0] seen_identifier;
  } result_t;

  // Ones' complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: rtl/icmp_erc_if.sv
// Stream interfaces for received datagram bytes and classification results.
`timescale 1ns / 1ps

interface icmp_erc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source(output valid, output packet_byte, output last_byte, input ready);
  modport sink(input valid, input packet_byte, input last_byte, output ready);
endinterface

interface icmp_erc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [7:0]  icmp_type;
  logic [15:0] seen_identifier;

  modport source(output valid, output verdict, output icmp_type, output seen_identifier,
                 input ready);
  modport sink(input valid, input verdict, input icmp_type, input seen_identifier,
               output ready);
endinterface

FILE: rtl/icmp_erc_core.sv
// Per-datagram parsing state, checksum accumulation and verdict logic.
`timescale 1ns / 1ps

module icmp_erc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_fire,
  input  logic [7:0]            packet_byte,
  input  logic                  last_byte,
  input  logic [15:0]           expected_identifier,
  output logic                  result_valid,
  output icmp_erc_pkg::result_t result
);
  import icmp_erc_pkg::*;

  logic [6:0]  byte_position;
  logic [5:0]  header_length;
  logic [15:0] sum_accumulator;
  logic [7:0]  held_high_byte;
  logic        odd_pending;
  logic [7:0]  type_seen;
  logic [15:0] identifier_seen;

  logic [5:0]  hl_cur;
  logic        in_icmp;
  logic        reached_id;
  logic [6:0]  icmp_offset;
  logic [15:0] add_word;
  logic [15:0] sum_add;
  logic [15:0] final_sum;
  logic [7:0]  type_next;
  logic [15:0] identifier_next;
  verdict_t    verdict;

  always_comb begin
    hl_cur      = (byte_position == 7'd0) ? {packet_byte[3:0] & IHL_MASK, 2'b00} : header_length;
    in_icmp     = byte_position >= {1'b0, hl_cur};
    reached_id  = {1'b0, byte_position} >= ({2'b00, hl_cur} + {1'b0, ID_LOW_OFFSET});
    icmp_offset = byte_position - {1'b0, hl_cur};
    add_word    = odd_pending ? {held_high_byte, packet_byte} : {packet_byte, 8'h00};
    sum_add     = ones_add(sum_accumulator, add_word);
    final_sum   = in_icmp ? sum_add : sum_accumulator;

    type_next       = type_seen;
    identifier_next = identifier_seen;
    if (in_icmp) begin
      if (icmp_offset == 7'd0) begin
        type_next = packet_byte;
      end else if (icmp_offset == ID_HIGH_OFFSET) begin
        identifier_next[15:8] = packet_byte;
      end else if (icmp_offset == ID_LOW_OFFSET) begin
        identifier_next[7:0] = packet_byte;
      end
    end

    priority if (final_sum != SUM_GOOD) begin
      verdict = VERDICT_BAD_CHECKSUM;
    end else if (in_icmp && type_next == ECHO_REQUEST_TYPE) begin
      verdict = VERDICT_OWN_REQUEST;
    end else if (!reached_id || type_next != 8'd0 ||
                 identifier_next != expected_identifier) begin
      verdict = VERDICT_ANOMALY;
    end else begin
      verdict = VERDICT_FOR_US;
    end

    result_valid           = byte_fire && last_byte;
    result.verdict         = verdict;
    result.icmp_type       = type_next;
    result.seen_identifier = identifier_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      header_length   <= '0;
      sum_accumulator <= '0;
      held_high_byte  <= '0;
      odd_pending     <= 1'b0;
      type_seen       <= '0;
      identifier_seen <= '0;
    end else if (byte_fire) begin
      if (last_byte) begin
        byte_position   <= '0;
        header_length   <= '0;
        sum_accumulator <= '0;
        held_high_byte  <= '0;
        odd_pending     <= 1'b0;
        type_seen       <= '0;
        identifier_seen <= '0;
      end else begin
        if (byte_position < POS_MAX) begin
          byte_position <= byte_position + 7'd1;
        end
        header_length   <= hl_cur;
        type_seen       <= type_next;
        identifier_seen <= identifier_next;
        if (in_icmp) begin
          if (odd_pending) begin
            sum_accumulator <= sum_add;
            held_high_byte  <= '0;
            odd_pending     <= 1'b0;
          end else begin
            held_high_byte <= packet_byte;
            odd_pending    <= 1'b1;
          end
        end
      end
    end
  end

endmodule

FILE: rtl/icmp_echo_reply_classifier.sv
// Top level of the ICMP echo reply classifier with result register and skid slot.
`timescale 1ns / 1ps

// Takes a received IPv4 datagram one byte per clock while ready is high, IP
// header first, and on the byte marked last delivers one verdict together
// with the ICMP type and echo identifier seen. The ICMP part is checked with
// the Internet checksum, and the identifier is compared against the value
// written on the configuration port, which should only be written while no
// datagram is in progress. The verdict is registered into the result
// register, or into a second result slot behind it while the register is
// stalled. The second slot keeps input ready high while one result waits,
// so input ready falls only when both slots hold results not yet taken.
module icmp_echo_reply_classifier (
  input  logic           clk,
  input  logic           rst,
  icmp_erc_in_if.sink    datagram,
  icmp_erc_out_if.source result,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data
);
  import icmp_erc_pkg::*;

  logic        byte_fire;
  logic        core_valid;
  result_t     core_result;
  logic [15:0] expected_identifier;
  logic        out_valid;
  result_t     out_data;
  logic        skid_valid;
  result_t     skid_data;
  logic        out_free;

  assign datagram.ready = !skid_valid;
  assign byte_fire      = datagram.valid && datagram.ready;
  assign out_free       = !out_valid || result.ready;

  icmp_erc_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .byte_fire           (byte_fire),
    .packet_byte         (datagram.packet_byte),
    .last_byte           (datagram.last_byte),
    .expected_identifier (expected_identifier),
    .result_valid        (core_valid),
    .result              (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_identifier <= '0;
    end else if (cfg_wr_en) begin
      expected_identifier <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= core_valid;
        skid_data  <= core_result;
      end else begin
        out_valid <= core_valid;
        out_data  <= core_result;
      end
    end else if (core_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= core_result;
    end
  end

  assign result.valid           = out_valid;
  assign result.verdict         = out_data.verdict;
  assign result.icmp_type       = out_data.icmp_type;
  assign result.seen_identifier = out_data.seen_identifier;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid slot holds a result while the result register is empty.");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready && core_valid) |=> skid_valid)
    else $error("A result produced during an output stall was lost.");

  a_skid_held: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_valid && !result.ready) |=> (skid_valid && $stable(skid_data)))
    else $error("Skid slot changed while the output was stalled.");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the ICMP echo reply classifier with a built-in verdict predictor.
`timescale 1ns / 1ps

module tb_top;
  import icmp_erc_pkg::*;

  typedef struct {
    logic [7:0] pkt_byte;
    logic       is_last;
    bit         typed;
    result_t    want;
  } dir_row_t;

  localparam result_t NOT_TYPED    = '0;
  localparam result_t BAD_EMPTY    = '{VERDICT_BAD_CHECKSUM, 8'h00, 16'h0000};
  localparam result_t FOR_US_ZERO  = '{VERDICT_FOR_US, 8'h00, 16'h0000};
  localparam result_t ANOMALY_FFFF = '{VERDICT_ANOMALY, 8'h00, 16'hFFFF};
  localparam int      DIR_ROWS     = 26;
  localparam int      PHASE_BYTES  = 230;
  localparam int      NUM_PHASES   = 5;
  localparam int      SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  icmp_erc_in_if  datagram_ch ();
  icmp_erc_out_if verdict_ch ();

  icmp_echo_reply_classifier dut (
    .clk         (clk),
    .rst         (rst),
    .datagram    (datagram_ch.sink),
    .result      (verdict_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  logic [6:0]  pred_pos;
  logic [5:0]  pred_hlen;
  logic [15:0] pred_sum;
  logic [7:0]  pred_held;
  logic        pred_odd;
  logic [7:0]  pred_type;
  logic [15:0] pred_ident;
  logic [15:0] pred_expected_id;

  result_t pending_verdicts [$];
  int      err_count = 0;
  int      random_bytes_sent = 0;
  bit      pace_on = 1'b1;
  logic [15:0] id_plan [NUM_PHASES];

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h45, 1'b1, 1'b1, BAD_EMPTY},
    '{8'hFF, 1'b1, 1'b1, BAD_EMPTY},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'hFF, 1'b0, 1'b0, NOT_TYPED},
    '{8'hFF, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b1, 1'b1, FOR_US_ZERO},
    '{8'h41, 1'b0, 1'b0, NOT_TYPED},
    '{8'hAA, 1'b0, 1'b0, NOT_TYPED},
    '{8'hBB, 1'b0, 1'b0, NOT_TYPED},
    '{8'hCC, 1'b0, 1'b0, NOT_TYPED},
    '{8'h08, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'hF7, 1'b0, 1'b0, NOT_TYPED},
    '{8'hFF, 1'b1, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'hFF, 1'b0, 1'b0, NOT_TYPED},
    '{8'hFF, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b0, 1'b0, NOT_TYPED},
    '{8'h00, 1'b1, 1'b1, ANOMALY_FFFF}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[15:0] + {15'd0, wide[16]};
  endfunction

  function automatic logic [15:0] icmp_sum(input logic [7:0] bytes [$], input int start);
    logic [15:0] acc;
    logic [7:0]  low;
    acc = 16'h0000;
    for (int i = start; i < bytes.size(); i += 2) begin
      low = (i + 1 < bytes.size()) ? bytes[i + 1] : 8'h00;
      acc = fold_add(acc, {bytes[i], low});
    end
    return acc;
  endfunction

  task automatic clear_datagram_state();
    pred_pos   = '0;
    pred_hlen  = '0;
    pred_sum   = '0;
    pred_held  = '0;
    pred_odd   = 1'b0;
    pred_type  = '0;
    pred_ident = '0;
  endtask

  task automatic classify_byte(input logic [7:0] b, input logic is_last, output bit has_result,
                               output result_t r);
    logic [6:0]  p;
    logic [6:0]  off;
    logic [15:0] total;
    bit          reached_type;
    bit          reached_id;
    p = pred_pos;
    if (p == 7'd0) begin
      pred_hlen = {b[3:0], 2'b00};
    end
    if (p >= {1'b0, pred_hlen}) begin
      off = p - {1'b0, pred_hlen};
      if (off == 7'd0) begin
        pred_type = b;
      end else if (off == ID_HIGH_OFFSET) begin
        pred_ident[15:8] = b;
      end else if (off == ID_LOW_OFFSET) begin
        pred_ident[7:0] = b;
      end
      if (pred_odd) begin
        pred_sum  = fold_add(pred_sum, {pred_held, b});
        pred_odd  = 1'b0;
        pred_held = 8'h00;
      end else begin
        pred_held = b;
        pred_odd  = 1'b1;
      end
    end
    if (pred_pos != POS_MAX) begin
      pred_pos = pred_pos + 7'd1;
    end
    has_result = is_last;
    r = '0;
    if (is_last) begin
      total = pred_sum;
      if (pred_odd) begin
        total = fold_add(total, {pred_held, 8'h00});
      end
      reached_type = p >= {1'b0, pred_hlen};
      reached_id   = {1'b0, p} >= ({2'b00, pred_hlen} + 8'd5);
      if (total != SUM_GOOD) begin
        r.verdict = VERDICT_BAD_CHECKSUM;
      end else if (reached_type && pred_type == ECHO_REQUEST_TYPE) begin
        r.verdict = VERDICT_OWN_REQUEST;
      end else if (!reached_id || pred_type != 8'h00 || pred_ident != pred_expected_id) begin
        r.verdict = VERDICT_ANOMALY;
      end else begin
        r.verdict = VERDICT_FOR_US;
      end
      r.icmp_type       = pred_type;
      r.seen_identifier = pred_ident;
      clear_datagram_state();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last, input bit typed,
                           input result_t want);
    int      gap;
    bit      has_result;
    result_t predicted;
    gap = pace_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      datagram_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    datagram_ch.valid       = 1'b1;
    datagram_ch.packet_byte = b;
    datagram_ch.last_byte   = is_last;
    do @(posedge clk); while (!datagram_ch.ready);
    classify_byte(b, is_last, has_result, predicted);
    if (has_result) begin
      pending_verdicts.push_back(typed ? want : predicted);
    end
    @(negedge clk);
  endtask

  task automatic send_packet();
    logic [7:0]  pkt [$];
    int          kind;
    int          ihl;
    int          icmp_len;
    int          hstart;
    int          cut;
    int          n;
    logic [7:0]  type_val;
    logic [15:0] id_val;
    logic [15:0] csum;
    kind    = $urandom_range(0, 19);
    pace_on = ($urandom_range(0, 3) != 0);
    if (kind == 17 || kind == 18) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        pkt.push_back(8'($urandom));
      end
    end else begin
      ihl      = ($urandom_range(0, 9) < 6) ? 5 : $urandom_range(0, 15);
      icmp_len = (kind == 19) ? $urandom_range(100, 140) : $urandom_range(8, 16);
      case ($urandom_range(0, 3))
        0, 1: type_val = 8'h00;
        2: type_val = ECHO_REQUEST_TYPE;
        default: type_val = 8'($urandom);
      endcase
      if (ihl == 0) begin
        type_val[3:0] = 4'h0;
      end
      id_val = ($urandom_range(0, 3) != 0) ? pred_expected_id : 16'($urandom);
      if (ihl != 0) begin
        pkt.push_back({4'($urandom), 4'(ihl)});
        for (int i = 1; i < ihl * 4; i++) begin
          pkt.push_back(8'($urandom));
        end
      end
      hstart = pkt.size();
      pkt.push_back(type_val);
      pkt.push_back(8'($urandom));
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      pkt.push_back(id_val[15:8]);
      pkt.push_back(id_val[7:0]);
      for (int i = 6; i < icmp_len; i++) begin
        pkt.push_back(8'($urandom));
      end
      csum = ~icmp_sum(pkt, hstart);
      if ($urandom_range(0, 7) == 0) begin
        csum = 16'($urandom);
      end
      pkt[hstart + 2] = csum[15:8];
      pkt[hstart + 3] = csum[7:0];
      if (kind >= 14 && kind <= 16) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) begin
          pkt.delete(pkt.size() - 1);
        end
      end
    end
    for (int i = 0; i < pkt.size(); i++) begin
      send_byte(pkt[i], i == pkt.size() - 1, 1'b0, NOT_TYPED);
    end
    random_bytes_sent += pkt.size();
  endtask

  task automatic drain_verdicts();
    datagram_ch.valid = 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_expected_id(input logic [15:0] value);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en        = 1'b0;
    pred_expected_id = value;
  endtask

  initial begin
    int      rx_wait;
    bit      took;
    result_t exp_r;
    rx_wait = 0;
    verdict_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      took = !rst && verdict_ch.valid && verdict_ch.ready;
      if (took) begin
        if (pending_verdicts.size() == 0) begin
          $error("result transfer with no verdict pending");
          err_count++;
        end else begin
          exp_r = pending_verdicts.pop_front();
          if (verdict_ch.verdict !== exp_r.verdict) begin
            $error("verdict: expected %0d, actual %0d", exp_r.verdict, verdict_ch.verdict);
            err_count++;
          end
          if (verdict_ch.icmp_type !== exp_r.icmp_type) begin
            $error("icmp_type: expected 0x%02h, actual 0x%02h", exp_r.icmp_type,
                   verdict_ch.icmp_type);
            err_count++;
          end
          if (verdict_ch.seen_identifier !== exp_r.seen_identifier) begin
            $error("seen_identifier: expected 0x%04h, actual 0x%04h", exp_r.seen_identifier,
                   verdict_ch.seen_identifier);
            err_count++;
          end
        end
      end
      @(negedge clk);
      if (took) begin
        rx_wait = pace_on ? $urandom_range(0, 3) : 0;
      end
      if (rx_wait > 0) begin
        verdict_ch.ready = 1'b0;
        rx_wait--;
      end else begin
        verdict_ch.ready = 1'b1;
      end
    end
  end

  initial begin
    rst                     = 1'b1;
    cfg_wr_en               = 1'b0;
    cfg_wr_data             = 16'h0000;
    datagram_ch.valid       = 1'b0;
    datagram_ch.packet_byte = 8'h00;
    datagram_ch.last_byte   = 1'b0;
    pred_expected_id        = 16'h0000;
    clear_datagram_state();
    id_plan[0] = 16'hFFFF;
    id_plan[1] = 16'($urandom);
    id_plan[2] = 16'h0001;
    id_plan[3] = 16'h8000;
    id_plan[4] = 16'($urandom);
    repeat (10) @(negedge clk);
    rst = 1'b0;
    write_expected_id(16'h0000);
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_rows[i].pkt_byte, dir_rows[i].is_last, dir_rows[i].typed, dir_rows[i].want);
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_verdicts();
      write_expected_id(id_plan[ph]);
      while (random_bytes_sent < (ph + 1) * PHASE_BYTES) begin
        send_packet();
      end
    end
    drain_verdicts();
    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
